// ----- rtl/core/zero_run_expand_and_relocate_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the zero run expander
// Short forms for same-cycle and next-cycle implications on clock and reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_EXPAND_AND_RELOCATE_MACROS_SVH
`define ZERO_RUN_EXPAND_AND_RELOCATE_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define ZRER_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zrer check failed");

// Next-cycle implication, quiet while reset is high
`define ZRER_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zrer check failed");

`endif

// ----- rtl/core/zrer_pkg.sv -----
// ----------------------------------------------------------------------------
// zrer_pkg
// Widths, item modes, status codes and register indexes of the expander.
// ----------------------------------------------------------------------------
package zrer_pkg;

   localparam int IMAGE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(IMAGE_DEPTH);
   localparam int POS_W       = $clog2(IMAGE_DEPTH + 1);
   localparam int SIZE_W      = 13;
   localparam int VAL_W       = 16;
   localparam int RADDR_W     = 12;
   localparam int DATA_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   // working width for size, position and displacement arithmetic
   localparam int CALC_W      = ((POS_W > VAL_W) ? POS_W : VAL_W) + 2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [1:0]        code_type;

   localparam code_type MODE_DATA  = 2'd0;
   localparam code_type MODE_COUNT = 2'd1;
   localparam code_type MODE_RELOC = 2'd2;
   localparam code_type MODE_READ  = 2'd3;

   localparam code_type ST_OK     = 2'd0;
   localparam code_type ST_BOUNDS = 2'd1;
   localparam code_type ST_ORDER  = 2'd2;
   localparam code_type ST_FAILED = 2'd3;

   localparam logic REG_IMAGE_SIZE   = 1'b0;
   localparam logic REG_BASE_ADDRESS = 1'b1;

   localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 13'd4096;

endpackage

// ----- rtl/core/zero_run_expand_and_relocate.sv -----
// ----------------------------------------------------------------------------
// zero_run_expand_and_relocate: image fill, zero run expansion and relocation
// A new word is taken only in IDLE, after the last one has been handed to the output.
// Reset clears fill, pending count and failure; image bytes hold until written.
// ----------------------------------------------------------------------------
module zero_run_expand_and_relocate
   import zrer_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [VAL_W-1:0]      req_item_value,
   input  logic [RADDR_W-1:0]    req_read_address,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_read_byte,
   output logic                  rsp_fill_done,
   output logic                  rsp_count_expected,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   // Sequencer states: every word leaves IDLE, does its memory work, then
   // parks in FIN until the response register is free.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DATA2 = 4'd1;   // write low byte of a data word
   localparam logic [3:0] S_ZERO  = 4'd2;   // write one zero byte per cycle
   localparam logic [3:0] S_RRD   = 4'd3;   // issue the four relocation reads
   localparam logic [3:0] S_RLAST = 4'd4;   // last read byte arrives
   localparam logic [3:0] S_RADD  = 4'd5;   // add the base address
   localparam logic [3:0] S_RWR   = 4'd6;   // write the four relocated bytes
   localparam logic [3:0] S_RDW   = 4'd7;   // read byte arrives
   localparam logic [3:0] S_FIN   = 4'd8;   // hand the result to the output

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [3:0]        state_ff,   state_in;
   logic [POS_W-1:0]  fill_ff,    fill_in;
   logic              await_ff,   await_in;
   logic              failed_ff,  failed_in;
   logic [SIZE_W-1:0] size_ff,    size_in;
   logic [DATA_W-1:0] base_ff,    base_in;
   logic [1:0]        idx_ff,     idx_in;
   logic              cap_ff,     cap_in;
   logic              rvalid_ff,  rvalid_in;

   addr_type          addr_ff,    addr_in;
   logic [POS_W-1:0]  cnt_ff,     cnt_in;
   logic [31:0]       word_ff,    word_in;
   logic [7:0]        lo_ff,      lo_in;
   logic [1:0]        status_ff,  status_in;
   logic [7:0]        rbyte_ff,   rbyte_in;
   logic [1:0]        rstatus_ff, rstatus_in;
   logic [7:0]        rrbyte_ff,  rrbyte_in;
   logic              rdone_ff,   rdone_in;
   logic              rcount_ff,  rcount_in;

   // ------------------------------------------------------------------------
   // Image memory: one write port, one read port, registered read data
   // ------------------------------------------------------------------------
   logic [7:0] mem [IMAGE_DEPTH];
   logic [7:0] mem_q_ff;
   logic       mem_we;
   addr_type   mem_wa;
   logic [7:0] mem_wd;
   logic       mem_re;
   addr_type   mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

   // ------------------------------------------------------------------------
   // Item checks, all taken against the state before the word
   // ------------------------------------------------------------------------
   logic              req_accept;
   logic [CALC_W-1:0] eff_size;
   logic [CALC_W-1:0] fill_c;
   logic [CALC_W-1:0] left;
   logic [CALC_W-1:0] val_c;
   logic [CALC_W-1:0] disp;
   logic [CALC_W-1:0] off;
   logic              full;
   logic              read_oob;
   logic [1:0]        item_status;
   logic              rsp_load;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);

   // saturate the configured size to the memory depth
   assign eff_size = (CALC_W'(size_ff) > CALC_W'(IMAGE_DEPTH)) ?
                     CALC_W'(IMAGE_DEPTH) : CALC_W'(size_ff);
   assign fill_c   = CALC_W'(fill_ff);
   assign left     = (fill_c < eff_size) ? (eff_size - fill_c) : '0;
   assign full     = (fill_c >= eff_size) && !await_ff;
   assign val_c    = CALC_W'(req_item_value);
   // sign-extend the displacement and measure it from the image end
   assign disp     = {{(CALC_W-VAL_W){req_item_value[VAL_W-1]}}, req_item_value};
   assign off      = eff_size + disp;
   assign read_oob = CALC_W'(req_read_address) >= CALC_W'(IMAGE_DEPTH);

   always_comb begin
      item_status = ST_OK;
      unique case (req_mode)
         MODE_READ: begin
            if (read_oob) begin
               item_status = ST_BOUNDS;
            end else if (failed_ff) begin
               item_status = ST_FAILED;
            end
         end
         MODE_DATA: begin
            if (failed_ff) begin
               item_status = ST_FAILED;
            end else if (await_ff || (fill_c >= eff_size)) begin
               item_status = ST_ORDER;
            end else if (left < CALC_W'(2)) begin
               item_status = ST_BOUNDS;
            end
         end
         MODE_COUNT: begin
            if (failed_ff) begin
               item_status = ST_FAILED;
            end else if (!await_ff) begin
               item_status = ST_ORDER;
            end else if (val_c > left) begin
               item_status = ST_BOUNDS;
            end
         end
         MODE_RELOC: begin
            if (failed_ff) begin
               item_status = ST_FAILED;
            end else if (!full) begin
               item_status = ST_ORDER;
            end else if (off[CALC_W-1] || ((off + CALC_W'(4)) > eff_size)) begin
               item_status = ST_BOUNDS;
            end
         end
         default: item_status = ST_OK;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      await_in   = await_ff;
      failed_in  = failed_ff;
      idx_in     = idx_ff;
      cap_in     = 1'b0;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      word_in    = word_ff;
      lo_in      = lo_ff;
      status_in  = status_ff;
      rbyte_in   = rbyte_ff;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = addr_ff;
      mem_wd     = 8'd0;
      mem_re     = 1'b0;
      mem_ra     = addr_ff;

      // shift each relocation byte in the cycle after its read, high byte first
      if (cap_ff) begin
         word_in = {word_ff[23:0], mem_q_ff};
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in = item_status;
               rbyte_in  = 8'd0;
               state_in  = S_FIN;
               if (req_mode == MODE_READ) begin
                  // a read leaves the state alone, even when out of range
                  if (!read_oob) begin
                     mem_re   = 1'b1;
                     mem_ra   = ADDR_W'(req_read_address);
                     state_in = S_RDW;
                  end
               end else if (item_status != ST_OK) begin
                  // a failing word only sets the sticky flag
                  failed_in = 1'b1;
               end else begin
                  unique case (req_mode)
                     MODE_DATA: begin
                        // write the high byte now, the low byte next cycle
                        mem_we   = 1'b1;
                        mem_wa   = ADDR_W'(fill_ff);
                        mem_wd   = req_item_value[15:8];
                        lo_in    = req_item_value[7:0];
                        addr_in  = ADDR_W'(fill_ff) + ADDR_W'(1);
                        fill_in  = fill_ff + POS_W'(2);
                        await_in = (req_item_value == '0);
                        state_in = S_DATA2;
                     end
                     MODE_COUNT: begin
                        addr_in  = ADDR_W'(fill_ff);
                        cnt_in   = POS_W'(val_c);
                        fill_in  = POS_W'(fill_c + val_c);
                        await_in = 1'b0;
                        state_in = (req_item_value == '0) ? S_FIN : S_ZERO;
                     end
                     MODE_RELOC: begin
                        addr_in  = ADDR_W'(off);
                        idx_in   = 2'd0;
                        state_in = S_RRD;
                     end
                     default: state_in = S_FIN;
                  endcase
               end
            end
         end
         S_DATA2: begin
            mem_we   = 1'b1;
            mem_wd   = lo_ff;
            state_in = S_FIN;
         end
         S_ZERO: begin
            // one zero byte per cycle until the run is spent
            mem_we  = 1'b1;
            mem_wd  = 8'd0;
            addr_in = addr_ff + ADDR_W'(1);
            cnt_in  = cnt_ff - POS_W'(1);
            if (cnt_ff == POS_W'(1)) begin
               state_in = S_FIN;
            end
         end
         S_RRD: begin
            mem_re = 1'b1;
            mem_ra = addr_ff + ADDR_W'(idx_ff);
            cap_in = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = S_RLAST;
            end
         end
         S_RLAST: begin
            state_in = S_RADD;
         end
         S_RADD: begin
            // wraps modulo 2^32
            word_in  = word_ff + base_ff;
            state_in = S_RWR;
         end
         S_RWR: begin
            // write back big-endian: byte 0 takes bits 31:24
            mem_we = 1'b1;
            mem_wa = addr_ff + ADDR_W'(idx_ff);
            mem_wd = 8'(word_ff >> {~idx_ff, 3'b000});
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = S_FIN;
            end
         end
         S_RDW: begin
            rbyte_in = mem_q_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is empty or being drained
            if (!rvalid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Output register: flags show the state after the word
   // ------------------------------------------------------------------------
   always_comb begin
      rvalid_in  = rvalid_ff;
      rstatus_in = rstatus_ff;
      rrbyte_in  = rrbyte_ff;
      rdone_in   = rdone_ff;
      rcount_in  = rcount_ff;
      if (rsp_load) begin
         rvalid_in  = 1'b1;
         rstatus_in = status_ff;
         rrbyte_in  = rbyte_ff;
         rdone_in   = full;
         rcount_in  = await_ff;
      end else if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_status         = rstatus_ff;
   assign rsp_read_byte      = rrbyte_ff;
   assign rsp_fill_done      = rdone_ff;
   assign rsp_count_expected = rcount_ff;

   // ------------------------------------------------------------------------
   // Register port: index taken from address bit 2, no wait states
   // ------------------------------------------------------------------------
   logic csr_write;
   logic csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      size_in = size_ff;
      base_in = base_ff;
      prdata  = '0;
      unique case (csr_index)
         REG_IMAGE_SIZE: begin
            prdata = DATA_W'(size_ff);
            if (csr_write) begin
               size_in = pwdata[SIZE_W-1:0];
            end
         end
         REG_BASE_ADDRESS: begin
            prdata = base_ff;
            if (csr_write) begin
               base_in = pwdata;
            end
         end
         default: prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flops
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         await_ff  <= 1'b0;
         failed_ff <= 1'b0;
         size_ff   <= IMAGE_SIZE_RESET;
         base_ff   <= '0;
         idx_ff    <= '0;
         cap_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         await_ff  <= await_in;
         failed_ff <= failed_in;
         size_ff   <= size_in;
         base_ff   <= base_in;
         idx_ff    <= idx_in;
         cap_ff    <= cap_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cnt_ff     <= cnt_in;
      word_ff    <= word_in;
      lo_ff      <= lo_in;
      status_ff  <= status_in;
      rbyte_ff   <= rbyte_in;
      rstatus_ff <= rstatus_in;
      rrbyte_ff  <= rrbyte_in;
      rdone_ff   <= rdone_in;
      rcount_ff  <= rcount_in;
   end

endmodule

// ----- rtl/core/zrer_checker.sv -----
// ----------------------------------------------------------------------------
// zrer_checker
// Port-level checks on the expander, bound to the top level.
// ----------------------------------------------------------------------------
`include "zero_run_expand_and_relocate_macros.svh"

module zrer_checker
   import zrer_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_fill_done,
   input logic       rsp_count_expected
);

   // a stalled word holds
   `ZRER_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_read_byte) && $stable(rsp_fill_done) && $stable(rsp_count_expected))

   // a pending count means the fill is not done
   `ZRER_ASSERT_SAME(a_done_excl, rsp_valid, !(rsp_fill_done && rsp_count_expected))

   // the block is busy right after it takes a word
   `ZRER_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // only a served read carries a byte
   `ZRER_ASSERT_SAME(a_byte_on_read, rsp_valid && (rsp_read_byte != 8'd0), (rsp_status == ST_OK) || (rsp_status == ST_FAILED))

endmodule

bind zero_run_expand_and_relocate zrer_checker u_zrer_checker (.*);

// ----- sim/tb_zero_run_expand_and_relocate.sv -----
// ----------------------------------------------------------------------------
// tb_zero_run_expand_and_relocate: self-checking bench for the image expander
// Drives data, zero run, relocation and read words through the valid/stall
// channel. It predicts every response from an image tracker of its own and
// compares each response field by field. The image grows over several size
// settings, and a single sticky error is forced near the end.
// ----------------------------------------------------------------------------
module tb_zero_run_expand_and_relocate;
   import zrer_pkg::*;

   localparam int QUIET_LIMIT = 20000;   // cycles with no word moving on either side
   localparam int END_SETTLE  = 24;      // wait at the end for late or spurious responses

   typedef struct packed {
      code_type   status;
      logic [7:0] read_byte;
      logic       fill_done;
      logic       count_expected;
   } word_result_t;

   // Image tracker: own copy of the fill state and registers, plus the queue
   // of responses that accepted words are still owed.
   class image_tracker;
      logic [7:0]        image [IMAGE_DEPTH];
      int                fill_pos;
      bit                awaiting;
      bit                failed;
      logic [SIZE_W-1:0] size_reg;
      logic [31:0]       base_reg;
      word_result_t      due_words [$];
      int                words_seen [4];
      int                results_checked;
      int                mismatches;

      function new();
         fill_pos = 0;
         awaiting = 1'b0;
         failed = 1'b0;
         size_reg = IMAGE_SIZE_RESET;
         base_reg = '0;
         results_checked = 0;
         mismatches = 0;
         foreach (words_seen[i]) words_seen[i] = 0;
      endfunction

      function int eff_size();
         return (int'(size_reg) > IMAGE_DEPTH) ? IMAGE_DEPTH : int'(size_reg);
      endfunction

      function bit image_full();
         return fill_pos >= eff_size() && !awaiting;
      endfunction

      function code_type apply_data(logic [15:0] value);
         int lim;
         lim = eff_size();
         if (awaiting || fill_pos >= lim) return ST_ORDER;
         if (lim - fill_pos < 2) return ST_BOUNDS;
         image[fill_pos] = value[15:8];
         image[fill_pos + 1] = value[7:0];
         fill_pos += 2;
         if (value == 16'h0000) awaiting = 1'b1;
         return ST_OK;
      endfunction

      function code_type apply_count(logic [15:0] run);
         int lim;
         int left;
         lim = eff_size();
         if (!awaiting) return ST_ORDER;
         left = (fill_pos < lim) ? lim - fill_pos : 0;
         if (int'(run) > left) return ST_BOUNDS;
         for (int i = 0; i < int'(run); i++) image[fill_pos + i] = 8'h00;
         fill_pos += int'(run);
         awaiting = 1'b0;
         return ST_OK;
      endfunction

      function code_type apply_reloc(logic [15:0] code);
         int          lim;
         int          off;
         logic [31:0] w;
         lim = eff_size();
         if (!image_full()) return ST_ORDER;
         off = lim + int'($signed(code));
         if (off < 0 || off + 4 > lim) return ST_BOUNDS;
         w = {image[off], image[off + 1], image[off + 2], image[off + 3]} + base_reg;
         {image[off], image[off + 1], image[off + 2], image[off + 3]} = w;
         return ST_OK;
      endfunction

      // Work out the response owed for one accepted word and queue it
      function void note_word(code_type mode, logic [15:0] value, logic [11:0] addr);
         word_result_t r;
         r = '0;
         words_seen[mode]++;
         if (mode == MODE_READ) begin
            if (int'(addr) >= IMAGE_DEPTH) begin
               r.status = ST_BOUNDS;
            end else begin
               r.read_byte = image[addr];
               r.status = failed ? ST_FAILED : ST_OK;
            end
         end else if (failed) begin
            r.status = ST_FAILED;
         end else begin
            case (mode)
               MODE_DATA:  r.status = apply_data(value);
               MODE_COUNT: r.status = apply_count(value);
               default:    r.status = apply_reloc(value);
            endcase
            if (r.status != ST_OK) failed = 1'b1;
         end
         r.fill_done = image_full();
         r.count_expected = awaiting;
         due_words.push_back(r);
      endfunction

      task report(string what);
         // keep the log short when the block is badly off
         if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_word(word_result_t got);
         word_result_t want;
         if (due_words.size() == 0) begin
            report("response with no word outstanding");
            return;
         end
         want = due_words.pop_front();
         results_checked++;
         if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
         if (got.read_byte !== want.read_byte)
            report($sformatf("read_byte %h, predicted %h", got.read_byte, want.read_byte));
         if (got.fill_done !== want.fill_done)
            report($sformatf("fill_done %b, predicted %b", got.fill_done, want.fill_done));
         if (got.count_expected !== want.count_expected)
            report($sformatf("count_expected %b, predicted %b",
                             got.count_expected, want.count_expected));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_mode = MODE_DATA;
   logic [VAL_W-1:0]      req_item_value = '0;
   logic [RADDR_W-1:0]    req_read_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [7:0]            rsp_read_byte;
   logic                  rsp_fill_done;
   logic                  rsp_count_expected;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0]     pwdata = '0;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   image_tracker tracker;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           quiet_cycles = 0;
   string        error_case = "none";

   zero_run_expand_and_relocate u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_item_value     (req_item_value),
      .req_read_address   (req_read_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_fill_done      (rsp_fill_done),
      .rsp_count_expected (rsp_count_expected),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at random; a zero percentage gives a clean stretch
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Sample responses at the rising edge, before the block updates its outputs
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         tracker.check_word(word_result_t'{rsp_status, rsp_read_byte,
                                           rsp_fill_done, rsp_count_expected});
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   // The longest legal quiet spell is a zero run over most of the image.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      stall_pct = rsp_pct;
   endtask

   // One register port transfer. Start and end on a falling edge and leave
   // psel high, so that back-to-back transfers drive each signal once per step.
   task automatic csr_transfer(input logic wr, input logic idx, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
   endtask

   // Write both registers, read each back, then release the port.
   // Call only when no response is outstanding.
   task automatic configure(input logic [SIZE_W-1:0] size, input logic [31:0] base);
      logic [31:0] back;
      csr_transfer(1'b1, REG_IMAGE_SIZE, 32'(size), back);
      tracker.size_reg = size;
      csr_transfer(1'b0, REG_IMAGE_SIZE, '0, back);
      if (back !== 32'(size))
         tracker.report($sformatf("image_size reads %h, written %h", back, size));
      csr_transfer(1'b1, REG_BASE_ADDRESS, base, back);
      tracker.base_reg = base;
      csr_transfer(1'b0, REG_BASE_ADDRESS, '0, back);
      if (back !== base)
         tracker.report($sformatf("base_address reads %h, written %h", back, base));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Present one word, hold it until accepted, and note it with the tracker.
   // Enter and leave on a falling edge.
   task automatic send_word(input code_type mode, input logic [15:0] value,
                            input logic [11:0] addr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_item_value <= value;
      req_read_address <= addr;
      do @(posedge clock); while (req_stall);
      tracker.note_word(mode, value, addr);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.due_words.size() != 0);
   endtask

   // Read one byte that has already been filled
   task automatic read_filled();
      send_word(MODE_READ, 16'($urandom), 12'($urandom_range(0, tracker.fill_pos - 1)));
   endtask

   // Fill up to the effective size with well-formed words: random data, zero
   // words followed by run counts, and stray reads of filled bytes. Pick run
   // lengths that leave an even number of bytes, so that data words can close
   // the image exactly; with an odd remainder, force a zero word first.
   task automatic fill_to_size(input bit pauses);
      int          left;
      int          run;
      logic [15:0] w;
      while (!tracker.image_full()) begin
         left = (tracker.fill_pos < tracker.eff_size()) ?
                tracker.eff_size() - tracker.fill_pos : 0;
         if (tracker.fill_pos > 0 && $urandom_range(0, 9) == 0) begin
            read_filled();
         end else if (tracker.awaiting) begin
            if (left <= 40 && $urandom_range(0, 3) == 0)
               run = left;
            else if ($urandom_range(0, 19) == 0)
               run = $urandom_range(0, (left < 200) ? left : 200);
            else
               run = $urandom_range(0, (left < 16) ? left : 16);
            if ((left - run) % 2 == 1) run++;
            send_word(MODE_COUNT, 16'(run), 12'($urandom));
         end else begin
            w = ($urandom_range(0, 7) == 0 || left % 2 == 1) ? 16'h0000 : 16'($urandom);
            send_word(MODE_DATA, w, 12'($urandom));
         end
         // now and then hold off until the block has answered everything
         if (pauses && $urandom_range(0, 49) == 0) drain_responses();
      end
   endtask

   // Random relocations inside the full image, mixed with reads
   task automatic relocate_and_read(input int words);
      int lim;
      int off;
      repeat (words) begin
         lim = tracker.eff_size();
         if (lim >= 4 && $urandom_range(0, 1) == 0) begin
            off = ($urandom_range(0, 7) == 0) ? lim - 4 : $urandom_range(0, lim - 4);
            send_word(MODE_RELOC, 16'(off - lim), 12'($urandom));
         end else begin
            read_filled();
         end
      end
   endtask

   // Force one sticky error. Enter with three bytes left below a saturated size.
   task automatic break_fill();
      case ($urandom_range(0, 7))
         0: begin
            error_case = "data overflow";
            send_word(MODE_DATA, 16'($urandom_range(1, 16'hFFFF)), 12'($urandom));
            send_word(MODE_DATA, 16'($urandom), 12'($urandom));
         end
         1: begin
            error_case = "relocation before fill done";
            send_word(MODE_RELOC, 16'hFFFC, 12'($urandom));
         end
         2: begin
            error_case = "count with none pending";
            send_word(MODE_COUNT, 16'($urandom), 12'($urandom));
         end
         3: begin
            error_case = "count overflow";
            send_word(MODE_DATA, 16'h0000, 12'($urandom));
            send_word(MODE_COUNT, 16'($urandom_range(2, 16'hFFFF)), 12'($urandom));
         end
         4: begin
            error_case = "data while a count is pending";
            send_word(MODE_DATA, 16'h0000, 12'($urandom));
            send_word(MODE_DATA, 16'($urandom), 12'($urandom));
         end
         default: begin
            // close the image at the saturated size, then misuse it
            send_word(MODE_DATA, 16'h0000, 12'($urandom));
            send_word(MODE_COUNT, 16'd1, 12'($urandom));
            send_word(MODE_RELOC, 16'hFFFC, 12'($urandom));
            send_word(MODE_READ, 16'($urandom), 12'hFFF);
            case ($urandom_range(0, 2))
               0: begin
                  error_case = "data after fill done";
                  send_word(MODE_DATA, 16'($urandom), 12'($urandom));
               end
               1: begin
                  error_case = "relocation past the image end";
                  send_word(MODE_RELOC, 16'($urandom_range(0, 16'h7FFF)), 12'($urandom));
               end
               default: begin
                  error_case = "relocation below byte zero";
                  send_word(MODE_RELOC, 16'($urandom_range(16'h8000, 16'hEFFF)),
                            12'($urandom));
               end
            endcase
         end
      endcase
   endtask

   // After the failure: every kind of word, reads kept to filled bytes
   task automatic stray_words(input int words);
      code_type mode;
      repeat (words) begin
         mode = code_type'($urandom_range(0, 3));
         if (mode == MODE_READ)
            read_filled();
         else
            send_word(mode, 16'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: small image, all-ones base, no idling. Walk the data
      // extremes, an empty zero run, an odd run, a pending count that must be
      // zero at a full image, relocations at both ends and a wrapping add.
      set_idling(0, 0);
      configure(13'd64, 32'hFFFF_FFFF);
      send_word(MODE_DATA, 16'hFFFF, 12'h000);
      send_word(MODE_DATA, 16'h8000, 12'hFFF);
      send_word(MODE_DATA, 16'h0001, 12'h555);
      send_word(MODE_DATA, 16'h0000, 12'hAAA);
      send_word(MODE_COUNT, 16'd0, 12'h000);
      send_word(MODE_DATA, 16'h00FF, 12'h000);
      send_word(MODE_DATA, 16'h0000, 12'h000);
      send_word(MODE_COUNT, 16'd5, 12'h000);
      send_word(MODE_READ, 16'hFFFF, 12'd0);
      send_word(MODE_READ, 16'h0000, 12'd16);
      send_word(MODE_DATA, 16'h0000, 12'h000);
      send_word(MODE_COUNT, 16'd43, 12'h000);
      send_word(MODE_DATA, 16'h0000, 12'h000);
      send_word(MODE_COUNT, 16'd0, 12'h000);
      send_word(MODE_RELOC, 16'hFFFC, 12'h000);
      send_word(MODE_RELOC, 16'hFFC0, 12'h000);
      send_word(MODE_RELOC, 16'hFFC0, 12'h000);
      send_word(MODE_RELOC, 16'hFFFB, 12'h000);
      send_word(MODE_READ, 16'h0000, 12'd0);
      send_word(MODE_READ, 16'h0000, 12'd3);
      send_word(MODE_READ, 16'h0000, 12'd63);
      drain_responses();

      // Grow the image with the sender idling, pausing now and then for the
      // responses to catch up
      set_idling(48, 0);
      configure(13'd1024, $urandom);
      fill_to_size(1'b1);
      relocate_and_read(100);
      drain_responses();

      // Grow again with the response side stalling and a zero base
      set_idling(0, 48);
      configure(13'd2048, 32'h0000_0000);
      fill_to_size(1'b0);
      relocate_and_read(100);
      drain_responses();

      // Both sides idling: shrink to nothing (image full, reads only), then
      // grow to an odd size just short of the depth
      set_idling(23, 23);
      configure(13'd0, $urandom);
      relocate_and_read(30);
      drain_responses();
      configure(13'd4093, $urandom);
      fill_to_size(1'b1);
      relocate_and_read(150);
      drain_responses();

      // Saturated size: force one sticky error, then keep feeding words
      configure(13'd8191, $urandom);
      break_fill();
      stray_words(60);
      drain_responses();

      // Let any late or spurious response show itself
      repeat (END_SETTLE) @(negedge clock);
      if (tracker.due_words.size() != 0)
         tracker.report("responses still outstanding at the end");

      $display("Covered %0d data, %0d count, %0d relocation and %0d read words; %0d checked.",
               tracker.words_seen[MODE_DATA], tracker.words_seen[MODE_COUNT],
               tracker.words_seen[MODE_RELOC], tracker.words_seen[MODE_READ],
               tracker.results_checked);
      $display("Image filled to %0d bytes over six size settings; sticky error: %s.",
               tracker.fill_pos, error_case);
      if (tracker.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/zrer_pkg.sv
rtl/core/zero_run_expand_and_relocate.sv
rtl/core/zrer_checker.sv
sim/tb_zero_run_expand_and_relocate.sv
